FILE: design/afr_pkg.sv
// ---------------------------------------------------------------------------
// afr_pkg
// Shared types, codes and constants of the API frame receiver.
// ---------------------------------------------------------------------------
package afr_pkg;

    // Parameter defaults
    localparam int unsigned MAX_FRAME_BYTES_DEF = 128;
    localparam int unsigned QUEUE_DEPTH_DEF     = 4;

    // Frame layout
    localparam logic [7:0] DELIM          = 8'h7E;
    localparam logic [7:0] SUM_OK         = 8'hFF;
    localparam logic [7:0] POS_LEN_HIGH   = 8'd1;
    localparam logic [7:0] POS_LEN_LOW    = 8'd2;
    localparam logic [7:0] POS_TYPE       = 8'd3;
    localparam logic [7:0] POS_ADDR_FIRST = 8'd4;
    localparam logic [7:0] POS_ADDR_LAST  = 8'd11;
    localparam logic [7:0] POS_STATE      = 8'd15;
    localparam logic [7:0] LEN_OVERHEAD   = 8'd4;
    localparam logic [7:0] MIN_COUNT      = 8'd3;

    // Result status codes
    localparam logic [2:0] STATUS_REPORT   = 3'd0;
    localparam logic [2:0] STATUS_BAD_SUM  = 3'd1;
    localparam logic [2:0] STATUS_OTHER    = 3'd2;
    localparam logic [2:0] STATUS_SHORT    = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_RX_TYPE_CODE      = 1'b0;
    localparam logic        REG_MIN_REPORT_LENGTH = 1'b1;
    localparam logic [7:0]  RX_TYPE_CODE_RST      = 8'd144;
    localparam logic [7:0]  MIN_REPORT_LENGTH_RST = 8'd12;

    typedef struct packed {
        logic [7:0] data;
        logic       is_delim;
    } t_byte_item;

    typedef struct packed {
        logic [7:0] rx_type_code;
        logic [7:0] min_report_length;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: design/afr_if.sv
// ---------------------------------------------------------------------------
// afr_if
// Valid/ready channels for received bytes and frame results.
// ---------------------------------------------------------------------------
interface afr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  frame_kind;
    logic [31:0] source_high;
    logic [31:0] source_low;
    logic [7:0]  relay_state;

    modport source (output valid, output status, output frame_kind, output source_high,
                    output source_low, output relay_state, input ready);
    modport sink   (input valid, input status, input frame_kind, input source_high,
                    input source_low, input relay_state, output ready);
endinterface

FILE: design/afr_queue.sv
// ---------------------------------------------------------------------------
// afr_queue
// Short queue of classified bytes between the front and the deframer.
// ---------------------------------------------------------------------------
module afr_queue #(
    parameter int unsigned QUEUE_DEPTH = afr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  afr_pkg::t_byte_item    i_item,
    input  logic                   i_pop,
    output afr_pkg::t_byte_item    o_item,
    output afr_pkg::t_queue_status o_status
);
    import afr_pkg::*;

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_byte_item       r_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] n_wr_idx;
    logic [IDX_W-1:0] n_rd_idx;
    logic [CNT_W-1:0] n_count;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_idx];

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (i_push) begin
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
        end
        if (i_pop) begin
            n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_idx] <= i_item;
        end
    end

endmodule

FILE: design/afr_deframer.sv
// ---------------------------------------------------------------------------
// afr_deframer
// Frame state machine: capture fields, sum bytes and register one result.
// ---------------------------------------------------------------------------
module afr_deframer #(
    parameter int unsigned MAX_FRAME_BYTES = afr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  afr_pkg::t_byte_item i_item,
    output logic                o_pop,
    input  afr_pkg::t_cfg       i_cfg,
    afr_result_if.source        o_res
);
    import afr_pkg::*;

    localparam logic [7:0] MAX_CNT = 8'(MAX_FRAME_BYTES);

    logic        r_framing;
    logic [7:0]  r_count;
    logic [15:0] r_len;
    logic [7:0]  r_sum;
    logic [7:0]  r_type;
    logic [63:0] r_addr;
    logic [7:0]  r_state;

    logic        n_framing;
    logic [7:0]  n_count;
    logic [15:0] n_len;
    logic [7:0]  n_sum;
    logic [7:0]  n_type;
    logic [63:0] n_addr;
    logic [7:0]  n_state;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [7:0]  r_out_kind;
    logic [63:0] r_out_addr;
    logic [7:0]  r_out_relay;

    logic        emit;
    logic [2:0]  emit_status;
    logic [7:0]  target;
    logic [7:0]  b;

    assign o_pop = i_item_valid && (!r_out_valid || o_res.ready);
    assign b     = i_item.data;

    always_comb begin
        n_framing   = r_framing;
        n_count     = r_count;
        n_len       = r_len;
        n_sum       = r_sum;
        n_type      = r_type;
        n_addr      = r_addr;
        n_state     = r_state;
        emit        = 1'b0;
        emit_status = STATUS_REPORT;
        target      = n_len[7:0] + LEN_OVERHEAD;
        if (o_pop) begin
            if (!r_framing) begin
                // drop anything but a delimiter while idle
                if (i_item.is_delim) begin
                    n_framing = 1'b1;
                    n_count   = 8'd1;
                    n_len     = '0;
                    n_sum     = '0;
                    n_type    = '0;
                    n_addr    = '0;
                    n_state   = '0;
                end
            end else begin
                n_count = r_count + 8'd1;
                if (r_count == POS_LEN_HIGH) begin
                    n_len = {b, 8'h00};
                end else if (r_count == POS_LEN_LOW) begin
                    n_len = {r_len[15:8], b};
                end else begin
                    n_sum = r_sum + b;
                    if (r_count == POS_TYPE) begin
                        n_type = b;
                    end else if (r_count >= POS_ADDR_FIRST && r_count <= POS_ADDR_LAST) begin
                        n_addr = {r_addr[55:0], b};
                    end else if (r_count == POS_STATE) begin
                        n_state = b;
                    end
                end
                target = n_len[7:0] + LEN_OVERHEAD;
                // targets below four never match; completion wins over abort
                if (n_count >= MIN_COUNT && n_len != '0 && target >= LEN_OVERHEAD
                        && n_count == target) begin
                    emit      = 1'b1;
                    n_framing = 1'b0;
                    if (n_sum != SUM_OK) begin
                        emit_status = STATUS_BAD_SUM;
                    end else if (n_type != i_cfg.rx_type_code) begin
                        emit_status = STATUS_OTHER;
                    end else if (n_len <= {8'h00, i_cfg.min_report_length}) begin
                        emit_status = STATUS_SHORT;
                    end else begin
                        emit_status = STATUS_REPORT;
                    end
                end else if (n_count >= MAX_CNT) begin
                    emit        = 1'b1;
                    emit_status = STATUS_OVERFLOW;
                    n_framing   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_framing   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_framing <= n_framing;
            r_count   <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_sum   <= n_sum;
        r_type  <= n_type;
        r_addr  <= n_addr;
        r_state <= n_state;
        if (emit) begin
            r_out_status <= emit_status;
            r_out_kind   <= n_type;
            r_out_addr   <= n_addr;
            r_out_relay  <= n_state;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.frame_kind  = r_out_kind;
    assign o_res.source_high = r_out_addr[63:32];
    assign o_res.source_low  = r_out_addr[31:0];
    assign o_res.relay_state = r_out_relay;

endmodule

FILE: design/api_frame_receiver.sv
// ---------------------------------------------------------------------------
// api_frame_receiver
// Serial API deframer: delimiter hunt, length, checksum and field capture.
// ---------------------------------------------------------------------------
// With the queue empty, the last byte passes through the byte queue and then the
// result register before the result is valid. Throughput: 1 byte per cycle while
// the result output is not stalled. A stalled result output holds the deframer;
// the byte queue holds up to QUEUE_DEPTH bytes before input ready drops.
// Reset (synchronous, active low): idle, queue empty, registers at defaults.
module api_frame_receiver #(
    parameter int unsigned MAX_FRAME_BYTES = afr_pkg::MAX_FRAME_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH     = afr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [afr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [afr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [afr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    afr_byte_if.sink                        i_rx,
    afr_result_if.source                    o_res
);
    import afr_pkg::*;

    logic [7:0]    r_type_code;
    logic [7:0]    r_min_len;
    logic          cfg_wr;
    logic          push;
    logic          pop;
    t_byte_item    in_item;
    t_byte_item    q_item;
    t_queue_status q_status;
    t_cfg          cfg;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_code <= RX_TYPE_CODE_RST;
            r_min_len   <= MIN_REPORT_LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_RX_TYPE_CODE:      r_type_code <= pwdata[7:0];
                REG_MIN_REPORT_LENGTH: r_min_len   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RX_TYPE_CODE:      prdata = {24'h000000, r_type_code};
            REG_MIN_REPORT_LENGTH: prdata = {24'h000000, r_min_len};
            default:               prdata = '0;
        endcase
    end

    assign cfg.rx_type_code      = r_type_code;
    assign cfg.min_report_length = r_min_len;

    // front: classify each byte and queue it
    assign i_rx.ready       = !q_status.full;
    assign push             = i_rx.valid && i_rx.ready;
    assign in_item.data     = i_rx.rx_byte;
    assign in_item.is_delim = (i_rx.rx_byte == DELIM);

    afr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (in_item),
        .i_pop    (pop),
        .o_item   (q_item),
        .o_status (q_status)
    );

    afr_deframer #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_deframer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!q_status.empty),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_cfg        (cfg),
        .o_res        (o_res)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_status.empty) |=> !q_status.empty)
        else $error("accepted byte lost from empty queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("deframer popped an empty queue");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status <= STATUS_OVERFLOW))
        else $error("result status out of range");

endmodule

FILE: sim/afr_checker.sv
// ---------------------------------------------------------------------------
// afr_frame_checker
// Watches the byte and result channels and the register port of the API
// frame receiver. It runs its own deframer on every accepted byte, queues
// the frame reports that must come out and compares each accepted result
// field by field with the oldest one.
// ---------------------------------------------------------------------------
module afr_frame_checker
    import afr_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    afr_byte_if                   i_rx,
    afr_result_if                 i_res,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  frame_kind;
        logic [31:0] source_high;
        logic [31:0] source_low;
        logic [7:0]  relay_state;
    } t_frame_report;

    logic [7:0]    cfg_type_code;
    logic [7:0]    cfg_min_length;
    logic          framing;
    logic [7:0]    byte_count;
    logic [15:0]   frame_length;
    logic [7:0]    running_sum;
    logic [7:0]    type_byte;
    logic [63:0]   source_addr;
    logic [7:0]    state_byte;
    t_frame_report due_reports[$];
    int            mismatch_count = 0;
    int            due_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = due_count;

    task automatic clear_capture();
        framing      = 1'b0;
        byte_count   = 8'd0;
        frame_length = 16'd0;
        running_sum  = 8'd0;
        type_byte    = 8'd0;
        source_addr  = 64'd0;
        state_byte   = 8'd0;
    endtask

    task automatic post_report(input logic [2:0] status);
        t_frame_report rep;
        rep.status      = status;
        rep.frame_kind  = type_byte;
        rep.source_high = source_addr[63:32];
        rep.source_low  = source_addr[31:0];
        rep.relay_state = state_byte;
        due_reports.push_back(rep);
        clear_capture();
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] pos;
        logic [7:0] target;
        if (!framing) begin
            // drop everything but the delimiter while hunting
            if (b == DELIM) begin
                clear_capture();
                framing    = 1'b1;
                byte_count = 8'd1;
            end
        end else begin
            pos        = byte_count;
            byte_count = byte_count + 8'd1;
            if (pos == POS_LEN_HIGH) begin
                frame_length = {b, 8'h00};
            end else if (pos == POS_LEN_LOW) begin
                frame_length[7:0] = b;
            end else begin
                running_sum = running_sum + b;
                if (pos == POS_TYPE)
                    type_byte = b;
                else if (pos >= POS_ADDR_FIRST && pos <= POS_ADDR_LAST)
                    source_addr = {source_addr[55:0], b};
                else if (pos == POS_STATE)
                    state_byte = b;
            end
            // target wraps at 8 bits; a target below the header size never hits
            target = frame_length[7:0] + LEN_OVERHEAD;
            if (byte_count >= MIN_COUNT && frame_length != 16'd0 &&
                target >= LEN_OVERHEAD && byte_count == target) begin
                if (running_sum != SUM_OK)
                    post_report(STATUS_BAD_SUM);
                else if (type_byte != cfg_type_code)
                    post_report(STATUS_OTHER);
                else if (frame_length <= {8'h00, cfg_min_length})
                    post_report(STATUS_SHORT);
                else
                    post_report(STATUS_REPORT);
            end else if (byte_count >= MAX_FRAME_BYTES) begin
                post_report(STATUS_OVERFLOW);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_report want;
        if (!i_rst_n) begin
            cfg_type_code  = RX_TYPE_CODE_RST;
            cfg_min_length = MIN_REPORT_LENGTH_RST;
            clear_capture();
            due_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_RX_TYPE_CODE, 2'b00})
                    cfg_type_code = i_pwdata[7:0];
                else if (i_paddr == {REG_MIN_REPORT_LENGTH, 2'b00})
                    cfg_min_length = i_pwdata[7:0];
            end
            if (i_res.valid && i_res.ready) begin
                if (due_reports.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, got status %0d",
                             $time, i_res.status);
                    mismatch_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("status", 32'(want.status), 32'(i_res.status));
                    check_field("frame_kind", 32'(want.frame_kind), 32'(i_res.frame_kind));
                    check_field("source_high", want.source_high, i_res.source_high);
                    check_field("source_low", want.source_low, i_res.source_low);
                    check_field("relay_state", 32'(want.relay_state), 32'(i_res.relay_state));
                end
            end
            if (i_rx.valid && i_rx.ready)
                deframe_byte(i_rx.rx_byte);
        end
        due_count = due_reports.size();
    end

endmodule

FILE: sim/api_frame_receiver_tb.sv
// ---------------------------------------------------------------------------
// api_frame_receiver_tb
// Drives byte streams into the API frame receiver: a directed set of frames
// covering the checksum, type, length and overflow corners, then random
// frames under several register settings. Input bursts and output stalls
// are random; the checker beside the block does all comparing.
// ---------------------------------------------------------------------------
module api_frame_receiver_tb;
    import afr_pkg::*;

    localparam int FRAME_LIMIT   = MAX_FRAME_BYTES_DEF;
    localparam int RANDOM_BYTES  = 760;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 4000;

    typedef enum int {RDY_OPEN, RDY_COIN, RDY_PULSE, RDY_STARVE} t_ready_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending_count;
    logic [7:0]            cur_type_code;
    logic [7:0]            cur_min_length;
    int                    burst_left;
    int                    frame_bytes;

    afr_byte_if   rx_ch ();
    afr_result_if res_ch ();

    api_frame_receiver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    afr_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result ready: switch between stall patterns, each held for a random stretch
    initial begin
        t_ready_mode mode;
        int          mode_left;
        res_ch.ready = 1'b0;
        mode         = RDY_OPEN;
        mode_left    = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (mode)
                RDY_OPEN:  res_ch.ready <= 1'b1;
                RDY_COIN:  res_ch.ready <= 1'($urandom_range(0, 1));
                RDY_PULSE: res_ch.ready <= (mode_left % 5 == 0);
                default:   res_ch.ready <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [7:0] random_payload();
        return ($urandom_range(0, 15) == 0) ? DELIM : 8'($urandom_range(0, 255));
    endfunction

    task automatic push_rx_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(200, 400);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 9);
            end
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    // wait for every queued report, then give the block time to finish
    task automatic settle();
        rx_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] code, input logic [7:0] min_len);
        write_reg({REG_RX_TYPE_CODE, 2'b00}, code);
        write_reg({REG_MIN_REPORT_LENGTH, 2'b00}, min_len);
        cur_type_code  = code;
        cur_min_length = min_len;
    endtask

    // Build a frame that ends on its checksum where the length allows it,
    // else run it out to the abort count. A nonzero cut stops it early.
    task automatic send_frame(input logic [15:0] length, input logic [7:0] kind,
                              input logic [63:0] src, input logic [7:0] relay,
                              input bit bad_sum, input int cut);
        int         target;
        int         n;
        bit         completes;
        logic [7:0] sum;
        logic [7:0] b;
        target    = (int'(length) + 4) % 256;
        completes = (length != 16'd0) && (target >= 4) && (target <= FRAME_LIMIT);
        n         = completes ? target : FRAME_LIMIT;
        if (cut > 0 && cut < n)
            n = cut;
        sum = 8'd0;
        for (int pos = 0; pos < n; pos++) begin
            if (pos == 0) begin
                b = DELIM;
            end else if (pos == 1) begin
                b = length[15:8];
            end else if (pos == 2) begin
                b = length[7:0];
            end else begin
                if (completes && pos == target - 1) begin
                    b = SUM_OK - sum;
                    if (bad_sum)
                        b = b + 8'($urandom_range(1, 255));
                end else if (pos == int'(POS_TYPE)) begin
                    b = kind;
                end else if (pos >= int'(POS_ADDR_FIRST) && pos <= int'(POS_ADDR_LAST)) begin
                    b = src[8 * (int'(POS_ADDR_LAST) - pos) +: 8];
                end else if (pos == int'(POS_STATE)) begin
                    b = relay;
                end else begin
                    b = random_payload();
                end
                sum = sum + b;
            end
            push_rx_byte(b);
            frame_bytes++;
        end
    endtask

    task automatic send_random_frame();
        int          r;
        int          cut;
        logic [15:0] length;
        logic [7:0]  kind;
        // line noise between frames
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6)) push_rx_byte(8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        if (r < 65)
            length = 16'($urandom_range(1, 24));
        else if (r < 78)
            length = 16'($urandom_range(25, 124));
        else if (r < 83)
            length = 16'($urandom_range(125, 255));
        else if (r < 89)
            length = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
        else if (r < 91)
            length = 16'd0;
        else
            length = {8'h00, cur_min_length} + 16'($urandom_range(0, 1));
        kind = ($urandom_range(0, 99) < 65) ? cur_type_code : 8'($urandom_range(0, 255));
        cut  = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 12) : 0;
        send_frame(length, kind, {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 6) == 0, cut);
    endtask

    initial begin
        int phase_end;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_rst_n        = 1'b0;
        burst_left     = 0;
        frame_bytes    = 0;
        cur_type_code  = RX_TYPE_CODE_RST;
        cur_min_length = MIN_REPORT_LENGTH_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle bytes are dropped
        push_rx_byte(8'h00);
        push_rx_byte(8'hFF);
        push_rx_byte(8'h7D);
        push_rx_byte(8'h7F);
        send_frame(16'd16, cur_type_code, 64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 1'b0, 0);
        send_frame(16'd16, cur_type_code, 64'h0, 8'hFF, 1'b1, 0);
        send_frame(16'd13, ~cur_type_code, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 0);
        // length one above and at the report minimum
        send_frame(16'd13, cur_type_code, 64'h8000_0000_0000_0001, 8'h80, 1'b0, 0);
        send_frame(16'd12, cur_type_code, 64'h5555_AAAA_5555_AAAA, 8'h02, 1'b0, 0);
        // too short to reach the whole address and the state byte
        send_frame(16'd5, cur_type_code, 64'hDEAD_BEEF_0BAD_F00D, 8'h33, 1'b0, 0);
        // zero length and a wrapped target below the header never complete
        send_frame(16'd0, cur_type_code, 64'h1, 8'h01, 1'b0, 0);
        send_frame(16'hFFFF, cur_type_code, 64'h2, 8'h01, 1'b0, 0);
        // target wraps to the header size: the checksum is the type byte
        send_frame(16'h0100, cur_type_code, 64'h3, 8'h01, 1'b0, 0);
        // completion on the abort count, then one past it
        send_frame(16'd124, cur_type_code, 64'hCAFE_0000_0000_BABE, 8'h01, 1'b0, 0);
        send_frame(16'd125, cur_type_code, 64'h4, 8'h01, 1'b0, 0);
        // delimiters inside a frame are plain data
        send_frame(16'd20, cur_type_code, 64'h7E7E_7E7E_7E7E_7E7E, 8'h7E, 1'b0, 0);
        // broken frame swallows the next one
        send_frame(16'd20, cur_type_code, 64'h5, 8'h01, 1'b0, 6);
        send_frame(16'd14, cur_type_code, 64'h6, 8'h01, 1'b0, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0:       set_config(RX_TYPE_CODE_RST, MIN_REPORT_LENGTH_RST);
                1:       set_config(8'h00, 8'h00);
                2:       set_config(8'hFF, 8'hFF);
                default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)));
            endcase
            phase_end = frame_bytes + RANDOM_BYTES / PHASES;
            while (frame_bytes < phase_end)
                send_random_frame();
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/afr_pkg.sv
design/afr_if.sv
design/afr_queue.sv
design/afr_deframer.sv
design/api_frame_receiver.sv
sim/afr_checker.sv
sim/api_frame_receiver_tb.sv
